FILE: design/dtic_pkg.sv
// Shared types, codes and helpers for the double to integer converter.
package dtic_pkg;

	typedef enum logic [2:0] {
		FUNC_TRUNC32 = 3'd0,
		FUNC_EXACT32 = 3'd1,
		FUNC_TRUNC64 = 3'd2,
		FUNC_TRUNCU64 = 3'd3,
		FUNC_WRAP32 = 3'd4
	} func_t;

	typedef struct packed {
		logic [63:0] int_result;
		logic        ok;
	} conv_res_t;

	localparam logic [63:0] INDEFINITE64 = 64'h8000_0000_0000_0000;
	localparam logic [63:0] INDEFINITE32 = 64'hFFFF_FFFF_8000_0000;
	localparam logic [63:0] NEG_ZERO_BITS = 64'h8000_0000_0000_0000;
	localparam logic [10:0] EXP_BIAS = 11'd1023;
	localparam logic [10:0] EXP_UNIT = 11'd1075;
	localparam logic [10:0] EXP_TWO63 = 11'd1086;
	localparam logic [10:0] EXP_MAX = 11'd2047;
	localparam logic [52:0] MAGIC_SIG = 53'h18_0000_0000_0000;

	// Count of leading zeros of a 56-bit word; 56 when the word is zero.
	function automatic logic [5:0] lzc56(input logic [55:0] x);
		logic [5:0] n;
		logic       found;
		n = 6'd56;
		found = 1'b0;
		for (int i = 55; i >= 0; i--) begin
			if (!found && x[i]) begin
				n = 6'(55 - i);
				found = 1'b1;
			end
		end
		return n;
	endfunction

endpackage

FILE: design/double_to_integer_convert.sv
// Top level of the double to integer converter with its two pipeline registers.
//
//   Channel  Handshake              Word contents
//   -------  ---------------------  ---------------------------------
//   cmd      cmd_valid, cmd_stall   func (3 bits), value_bits (64 bits)
//   rsp      rsp_valid, rsp_stall   int_result (64 bits), ok (1 bit)
//
// A word passes from acceptance to its result through the input register
// and then the result register. The conversion itself is a single
// combinational pass between those two registers, so one word is accepted in
// every cycle while the response side keeps taking results.
// Reset empties both registers; no other state exists.
// A stalled result holds the result register, and the input register then
// raises cmd_stall only when it holds a word that cannot move forward.
module double_to_integer_convert (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic [2:0]  func,
	input  logic [63:0] value_bits,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [63:0] int_result,
	output logic        ok
);
	import dtic_pkg::*;

	logic               valid_s1;
	logic [2:0]         func_s1;
	logic [63:0]        bits_s1;
	logic               valid_s2;
	conv_res_t          res_s2;
	logic               move_s2;
	conv_res_t          trunc_res;
	logic [31:0]        wrap_low;
	logic               nan_s1;
	conv_res_t          conv_res;

	// The result register is free when it is empty or its word leaves now.
	assign move_s2 = !valid_s2 || !rsp_stall;
	assign cmd_stall = valid_s1 && !move_s2;

	dtic_trunc u_trunc (
		.func       (func_s1),
		.value_bits (bits_s1),
		.res        (trunc_res)
	);

	dtic_wrap u_wrap (
		.value_bits (bits_s1),
		.low_word   (wrap_low)
	);

	// The wrap mode passes a NaN's low payload through unchanged; every other
	// mode takes its answer from the truncation unit.
	always_comb begin
		nan_s1 = (bits_s1[62:52] == EXP_MAX) && (bits_s1[51:0] != 52'd0);
		conv_res = trunc_res;
		if (func_s1 == FUNC_WRAP32) begin
			conv_res.ok = 1'b1;
			if (nan_s1) begin
				conv_res.int_result = {{32{bits_s1[31]}}, bits_s1[31:0]};
			end else begin
				conv_res.int_result = {{32{wrap_low[31]}}, wrap_low};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			func_s1 <= func;
			bits_s1 <= value_bits;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (move_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s2 && valid_s1) begin
			res_s2 <= conv_res;
		end
	end

	assign rsp_valid = valid_s2;
	assign int_result = res_s2.int_result;
	assign ok = res_s2.ok;

endmodule

FILE: design/dtic_trunc.sv
// Truncating conversions to int32, checked int32, int64 and uint64.
module dtic_trunc (
	input  logic [2:0]         func,
	input  logic [63:0]        value_bits,
	output dtic_pkg::conv_res_t res
);
	import dtic_pkg::*;

	logic        sgn;
	logic [10:0] ex;
	logic [51:0] fr;
	logic [52:0] sig;
	logic        nan;
	logic [10:0] ldiff;
	logic [10:0] rdiff;
	logic [63:0] sig_w;
	logic [63:0] mag;
	logic [63:0] neg_mag;
	logic [63:0] signed_mag;
	logic        frac_nz;
	logic        in32;
	logic        in64;
	logic [63:0] t32;
	logic [63:0] res64;

	always_comb begin
		sgn = value_bits[63];
		ex = value_bits[62:52];
		fr = value_bits[51:0];
		sig = {(ex != 11'd0), fr};
		nan = (ex == EXP_MAX) && (fr != 52'd0);
		sig_w = {11'd0, sig};
		ldiff = ex - EXP_UNIT;
		rdiff = EXP_UNIT - ex;

		if (ex < EXP_BIAS) begin
			mag = 64'd0;
			frac_nz = |value_bits[62:0];
		end else if (ex >= EXP_UNIT) begin
			mag = sig_w << ldiff[3:0];
			frac_nz = 1'b0;
		end else begin
			mag = sig_w >> rdiff[5:0];
			frac_nz = (sig_w & ((64'd1 << rdiff[5:0]) - 64'd1)) != 64'd0;
		end
		neg_mag = 64'd0 - mag;
		signed_mag = sgn ? neg_mag : mag;

		// Infinity and NaN carry the top exponent and fall outside both ranges.
		in32 = (ex <= EXP_TWO63) &&
			(sgn ? (mag <= 64'h8000_0000) : (mag < 64'h8000_0000));
		in64 = (ex < EXP_TWO63) || (sgn && (ex == EXP_TWO63) && (fr == 52'd0));

		t32 = in32 ? {{32{signed_mag[31]}}, signed_mag[31:0]} : INDEFINITE32;
		res64 = in64 ? signed_mag : INDEFINITE64;

		res.ok = 1'b1;
		case (func)
			FUNC_TRUNC32: res.int_result = t32;
			FUNC_EXACT32: begin
				if (in32 && !frac_nz && (value_bits != NEG_ZERO_BITS)) begin
					res.int_result = t32;
				end else begin
					res.int_result = 64'd0;
					res.ok = 1'b0;
				end
			end
			FUNC_TRUNC64: res.int_result = res64;
			FUNC_TRUNCU64: begin
				// At or above 2^63 the offset path gives the magnitude itself,
				// and zero once the value reaches 2^64.
				if (!sgn && !nan && (ex >= EXP_TWO63)) begin
					res.int_result = (ex == EXP_TWO63) ? mag : 64'd0;
				end else begin
					res.int_result = res64;
				end
			end
			default: begin
				res.int_result = 64'd0;
				res.ok = 1'b0;
			end
		endcase
	end

endmodule

FILE: design/dtic_wrap.sv
// Rounded addition of 2^52+2^51 to a double, giving the low fraction word.
module dtic_wrap (
	input  logic [63:0] value_bits,
	output logic [31:0] low_word
);
	import dtic_pkg::*;

	logic        sgn;
	logic [10:0] ex;
	logic [10:0] ea;
	logic [52:0] siga;
	logic        a_big;
	logic [52:0] big_sig;
	logic [52:0] small_sig;
	logic [10:0] shift_amt;
	logic [63:0] small_ext;
	logic [63:0] shifted;
	logic [63:0] lost_mask;
	logic        sticky;
	logic [55:0] aligned;
	logic [55:0] big_ext;
	logic [56:0] sum;
	logic [55:0] norm;
	logic [52:0] keep;
	logic        round_up;
	logic [52:0] rounded;

	always_comb begin
		sgn = value_bits[63];
		ex = value_bits[62:52];
		ea = (ex == 11'd0) ? 11'd1 : ex;
		siga = {(ex != 11'd0), value_bits[51:0]};

		a_big = (ea > EXP_UNIT) || ((ea == EXP_UNIT) && (siga >= MAGIC_SIG));
		big_sig = a_big ? siga : MAGIC_SIG;
		small_sig = a_big ? MAGIC_SIG : siga;
		shift_amt = a_big ? (ea - EXP_UNIT) : (EXP_UNIT - ea);

		// Align the smaller operand with guard, round and sticky positions.
		small_ext = {8'd0, small_sig, 3'd0};
		if (shift_amt >= 11'd64) begin
			shifted = 64'd0;
			lost_mask = {64{1'b1}};
		end else begin
			shifted = small_ext >> shift_amt[5:0];
			lost_mask = (64'd1 << shift_amt[5:0]) - 64'd1;
		end
		sticky = (small_ext & lost_mask) != 64'd0;
		aligned = {shifted[55:1], shifted[0] | sticky};
		big_ext = {big_sig, 3'd0};

		sum = sgn ? ({1'b0, big_ext} - {1'b0, aligned}) : ({1'b0, big_ext} + {1'b0, aligned});

		if (sum[56]) begin
			norm = {sum[56:2], sum[1] | sum[0]};
		end else begin
			norm = sum[55:0] << lzc56(sum[55:0]);
		end

		// Round to nearest, ties to even; a carry out leaves the low word zero.
		keep = norm[55:3];
		round_up = norm[2] && (norm[1] || norm[0] || keep[0]);
		rounded = keep + {52'd0, round_up};
		low_word = rounded[31:0];
	end

endmodule
